[rtl/core/stf_pkg.sv]
// Shared constants for the semaphore table with first-in first-out wait queues.
`default_nettype none

package stf_pkg;

  localparam int NUM_SEMS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int FUNC_W   = 2;
  localparam int PROC_W   = 8;
  localparam int SID_W    = 4;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] OP_WAIT   = 2'd1;
  localparam logic [FUNC_W-1:0] OP_SIGNAL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_QFULL  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

endpackage

`default_nettype wire

[rtl/core/stf_ram.sv]
// Single-port-write, single-port-read memory with a registered read.
`default_nettype none

module stf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire logic [Width-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AddrW-1:0] rd_addr,
  output logic      [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/semaphore_table_fifo_top.sv]
// Top level of the counting semaphore table with per-entry waiter queues.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+----------------------------------------------------
//   in      | in_valid, in_stall | func, proc_id, sem_id, init_value
//   out     | out_valid, out_stall | status, alloc_id, caller_blocks, wake_valid, wake_proc
//
// An allocate scans the valid bits one per cycle in the free-entry search (at most NUM_SEMS).
// A wait passes from the read state to the done state, and a signal that releases a waiter
// passes through the wake state between them, set by the registered reads of the entry memory and the waiter memory.
// Reset clears the valid bits, the sequencer and the output valid flag; the memories keep their
// contents. A new transfer is taken only when the sequencer is idle, and a finished result
// waits in the sequencer while the output register is stalled.
`default_nettype none

module semaphore_table_fifo_top #(
  parameter int NUM_SEMS    = stf_pkg::NUM_SEMS_DEF,
  parameter int QUEUE_DEPTH = stf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [stf_pkg::FUNC_W-1:0]   func,
  input  wire logic [stf_pkg::PROC_W-1:0]   proc_id,
  input  wire logic [stf_pkg::SID_W-1:0]    sem_id,
  input  wire logic [stf_pkg::COUNT_W-1:0]  init_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [stf_pkg::STATUS_W-1:0] status,
  output logic      [stf_pkg::SID_W-1:0]    alloc_id,
  output logic                              caller_blocks,
  output logic                              wake_valid,
  output logic      [stf_pkg::PROC_W-1:0]   wake_proc
);

  localparam int SemW   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QW     = $clog2(QUEUE_DEPTH);
  localparam int SzW    = $clog2(QUEUE_DEPTH + 1);
  localparam int MetaW  = stf_pkg::COUNT_W + QW + QW + SzW;
  localparam int WDepth = NUM_SEMS * QUEUE_DEPTH;
  localparam int WaW    = (WDepth > 1) ? $clog2(WDepth) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_WAKE   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                     state;
  logic [NUM_SEMS-1:0]            entry_valid;
  logic [SemW-1:0]                idx;
  logic [stf_pkg::FUNC_W-1:0]     func_q;
  logic [stf_pkg::PROC_W-1:0]     pid_q;
  logic [SemW-1:0]                sid_q;
  logic [stf_pkg::COUNT_W-1:0]    ival_q;
  logic [stf_pkg::STATUS_W-1:0]   res_status;
  logic [stf_pkg::SID_W-1:0]      res_alloc;
  logic                           res_blocks;
  logic                           res_wvalid;
  logic [stf_pkg::PROC_W-1:0]     res_wproc;

  logic                           accept;
  logic [SemW-1:0]                sid_in;
  logic                           sid_ok;
  logic                           meta_wr_en;
  logic [SemW-1:0]                meta_wr_addr;
  logic [MetaW-1:0]               meta_wr_data;
  logic [MetaW-1:0]               meta_rd_data;
  logic                           wt_wr_en;
  logic                           wt_rd_en;
  logic [WaW-1:0]                 wt_addr;
  logic [stf_pkg::PROC_W-1:0]     wt_rd_data;

  logic [stf_pkg::COUNT_W-1:0]    m_count;
  logic [QW-1:0]                  m_head;
  logic [QW-1:0]                  m_tail;
  logic [SzW-1:0]                 m_size;
  logic [QW-1:0]                  head_nx;
  logic [QW-1:0]                  tail_nx;
  logic                           is_wait;
  logic                           cnt_zero;
  logic                           q_full;
  logic                           q_empty;
  logic                           slot_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign sid_in   = SemW'(sem_id);
  assign sid_ok   = (32'(sem_id) < NUM_SEMS);

  assign {m_count, m_head, m_tail, m_size} = meta_rd_data;
  assign head_nx   = (32'(m_head) == QUEUE_DEPTH - 1) ? '0 : m_head + QW'(1);
  assign tail_nx   = (32'(m_tail) == QUEUE_DEPTH - 1) ? '0 : m_tail + QW'(1);
  assign is_wait   = (func_q == stf_pkg::OP_WAIT);
  assign cnt_zero  = (m_count == '0);
  assign q_full    = (m_size == SzW'(QUEUE_DEPTH));
  assign q_empty   = (m_size == '0);
  assign slot_free = !entry_valid[idx];

  always_comb begin
    meta_wr_en   = 1'b0;
    meta_wr_addr = sid_q;
    meta_wr_data = {m_count, m_head, m_tail, m_size};
    wt_wr_en     = 1'b0;
    wt_rd_en     = 1'b0;
    wt_addr      = WaW'(sid_q) * WaW'(QUEUE_DEPTH) + WaW'(m_tail);
    case (state)
      S_SEARCH: begin
        meta_wr_en   = slot_free;
        meta_wr_addr = idx;
        meta_wr_data = {ival_q, QW'(0), QW'(0), SzW'(0)};
      end
      S_READ: begin
        if (is_wait) begin
          if (!cnt_zero) begin
            meta_wr_en   = 1'b1;
            meta_wr_data = {m_count - 16'd1, m_head, m_tail, m_size};
          end else if (!q_full) begin
            meta_wr_en   = 1'b1;
            meta_wr_data = {m_count, m_head, tail_nx, m_size + SzW'(1)};
            wt_wr_en     = 1'b1;
          end
        end else begin
          if (!q_empty) begin
            meta_wr_en   = 1'b1;
            meta_wr_data = {m_count, head_nx, m_tail, m_size - SzW'(1)};
            wt_rd_en     = 1'b1;
            wt_addr      = WaW'(sid_q) * WaW'(QUEUE_DEPTH) + WaW'(m_head);
          end else if (m_count != stf_pkg::COUNT_MAX) begin
            meta_wr_en   = 1'b1;
            meta_wr_data = {m_count + 16'd1, m_head, m_tail, m_size};
          end
        end
      end
      default: begin
      end
    endcase
  end

  stf_ram #(
    .Width (MetaW),
    .Depth (NUM_SEMS)
  ) u_meta (
    .clk     (clk),
    .wr_en   (meta_wr_en),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr_data),
    .rd_en   (accept),
    .rd_addr (sid_in),
    .rd_data (meta_rd_data)
  );

  stf_ram #(
    .Width (stf_pkg::PROC_W),
    .Depth (WDepth)
  ) u_waiters (
    .clk     (clk),
    .wr_en   (wt_wr_en),
    .wr_addr (wt_addr),
    .wr_data (pid_q),
    .rd_en   (wt_rd_en),
    .rd_addr (wt_addr),
    .rd_data (wt_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            func_q     <= func;
            pid_q      <= proc_id;
            sid_q      <= sid_in;
            ival_q     <= init_value;
            idx        <= '0;
            res_status <= stf_pkg::ST_OK;
            res_alloc  <= '0;
            res_blocks <= 1'b0;
            res_wvalid <= 1'b0;
            res_wproc  <= '0;
            if (func == stf_pkg::OP_ALLOC) begin
              state <= S_SEARCH;
            end else if ((func == stf_pkg::OP_WAIT || func == stf_pkg::OP_SIGNAL) &&
                         sid_ok && entry_valid[sid_in]) begin
              state <= S_READ;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SEARCH: begin
          if (slot_free) begin
            entry_valid[idx] <= 1'b1;
            res_alloc        <= stf_pkg::SID_W'(idx);
            state            <= S_DONE;
          end else if (32'(idx) == NUM_SEMS - 1) begin
            res_status <= stf_pkg::ST_NOFREE;
            state      <= S_DONE;
          end else begin
            idx <= idx + SemW'(1);
          end
        end
        S_READ: begin
          if (is_wait) begin
            state <= S_DONE;
            if (cnt_zero) begin
              if (q_full) begin
                res_status <= stf_pkg::ST_QFULL;
              end else begin
                res_blocks <= 1'b1;
              end
            end
          end else if (!q_empty) begin
            res_wvalid <= 1'b1;
            state      <= S_WAKE;
          end else begin
            state <= S_DONE;
          end
        end
        S_WAKE: begin
          res_wproc <= wt_rd_data;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            alloc_id      <= res_alloc;
            caller_blocks <= res_blocks;
            wake_valid    <= res_wvalid;
            wake_proc     <= res_wproc;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
